@@ sv/eph_pkg.sv @@
// ---------------------------------------------------------------------------
// eph_pkg
// Shared types, constants and table helpers for the envelope phaser.
// ---------------------------------------------------------------------------
package eph_pkg;

    localparam int COEF_DEPTH = 256;

    localparam logic [25:0] ATTACK_Q32  = 26'd42949673;
    localparam logic [25:0] RELEASE_Q32 = 26'd429497;
    localparam logic [14:0] FB_MAX      = 15'd31129;
    localparam logic [15:0] ONE_Q15     = 16'd32768;

    localparam logic [15:0] QSINE [0:32] = '{
        16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,
        16'd9512,  16'd11039, 16'd12540, 16'd14010, 16'd15447, 16'd16846,
        16'd18205, 16'd19520, 16'd20788, 16'd22006, 16'd23170, 16'd24279,
        16'd25330, 16'd26319, 16'd27246, 16'd28106, 16'd28899, 16'd29622,
        16'd30274, 16'd30853, 16'd31357, 16'd31786, 16'd32138, 16'd32413,
        16'd32610, 16'd32729, 16'd32768
    };

    localparam logic [15:0] STAGE_RECIP [0:16] = '{
        16'd0,    16'd32768, 16'd16384, 16'd10923, 16'd8192, 16'd6554,
        16'd5461, 16'd4681,  16'd4096,  16'd3641,  16'd3277, 16'd2979,
        16'd2731, 16'd2521,  16'd2341,  16'd2185,  16'd2048
    };

    typedef enum logic [2:0] {
        CFG_DEPTH, CFG_FEEDBACK, CFG_WET, CFG_STAGES,
        CFG_LFO_STEP, CFG_CENTER, CFG_MIN_FREQ
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SIN, ST_SIN2, ST_ENV, ST_EFF, ST_SPR, ST_SPRW,
        ST_FREQ, ST_COEF, ST_INTP, ST_YMUL, ST_UPD,
        ST_MIX1, ST_MIX2, ST_MIX3, ST_FIN
    } t_state;

    typedef struct packed {
        logic signed [32:0] a;
        logic signed [26:0] b;
    } t_mul_req;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
    } t_sin_pts;

    typedef logic signed [24:0] t_coef;
    typedef t_coef t_coef_tab [0:COEF_DEPTH];

    // Pick the two quarter-wave points around a phase.
    function automatic t_sin_pts sin_pts(input logic [31:0] ph);
        logic [5:0] idx;
        t_sin_pts   p;
        idx = {1'b0, ph[29:25]};
        if (ph[30]) begin
            p.a = QSINE[6'd32 - idx];
            p.b = QSINE[6'd31 - idx];
        end else begin
            p.a = QSINE[idx];
            p.b = QSINE[idx + 6'd1];
        end
        return p;
    endfunction

    function automatic longint sine_full(input logic [31:0] ph);
        t_sin_pts p;
        longint   fr;
        longint   v;
        p  = sin_pts(ph);
        fr = longint'(ph[24:17]);
        v  = (longint'(p.a) * (256 - fr) + longint'(p.b) * fr) >>> 8;
        return ph[31] ? -v : v;
    endfunction

    // Restoring shift-subtract division, quotient truncated toward zero.
    // The divisor is positive.
    function automatic longint div_trunc(input longint num, input longint den);
        logic [63:0] num_mag;
        logic [63:0] den_mag;
        logic [63:0] quo;
        logic [63:0] part;
        num_mag = (num < 0) ? 64'(-num) : 64'(num);
        den_mag = 64'(den);
        quo     = '0;
        part    = '0;
        for (int i = 63; i >= 0; i--) begin
            part = {part[62:0], num_mag[i]};
            if (part >= den_mag) begin
                part   = part - den_mag;
                quo[i] = 1'b1;
            end
        end
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // All-pass coefficient (tan-1)/(tan+1) over a quarter turn, evaluated at elaboration.
    function automatic t_coef_tab build_coef_tab();
        t_coef_tab   tab;
        longint      s;
        longint      c;
        longint      den;
        logic [31:0] ph;
        for (int k = 0; k <= COEF_DEPTH; k++) begin
            ph  = 32'((longint'(k) << 30) / COEF_DEPTH);
            s   = sine_full(ph);
            c   = sine_full(32'(ph + 32'h4000_0000));
            den = s + c;
            if (den <= 0) begin
                den = 1;
            end
            tab[k] = t_coef'(div_trunc((s - c) * 8388608, den));
        end
        return tab;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

endpackage

@@ sv/eph_mul.sv @@
// ---------------------------------------------------------------------------
// eph_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module eph_mul (
    input  logic                   i_clk,
    input  eph_pkg::t_mul_req      i_req,
    output logic signed [59:0]     o_prod
);

    logic signed [59:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule

@@ sv/eph_coef.sv @@
// ---------------------------------------------------------------------------
// eph_coef
// All-pass coefficient table: base point, slope and fraction, registered.
// ---------------------------------------------------------------------------
module eph_coef (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [14:0]        i_freq,
    output logic signed [24:0] o_base,
    output logic signed [25:0] o_delta,
    output logic [15:0]        o_frac
);

    localparam eph_pkg::t_coef_tab COEF_TAB = eph_pkg::build_coef_tab();

    logic [8:0]         w_idx;
    logic signed [24:0] r_base;
    logic signed [25:0] r_delta;
    logic [15:0]        r_frac;

    // f * 2 * depth / 2^16: upper bits index, lower bits interpolate
    assign w_idx = {1'b0, i_freq[14:7]};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base  <= COEF_TAB[w_idx];
            r_delta <= 26'(COEF_TAB[w_idx + 9'd1]) - 26'(COEF_TAB[w_idx]);
            r_frac  <= {i_freq[6:0], 9'd0};
        end
    end

    assign o_base  = r_base;
    assign o_delta = r_delta;
    assign o_frac  = r_frac;

endmodule

@@ sv/envelope_modulated_phaser.sv @@
// Items are taken one at a time: the input stalls from acceptance until the result
// is loaded into the output register, which waits while the output is stalled.
// The single shared multiplier sets the pace: five steps per all-pass stage.
// Reset (synchronous, active low) restores register defaults and clears
// LFO phase, envelope, feedback and all stage histories at once.
// ---------------------------------------------------------------------------
// envelope_modulated_phaser
// Phaser with sine LFO and envelope-scaled depth sweeping a chain of
// first-order all-pass stages, sequenced over one shared multiplier.
// ---------------------------------------------------------------------------
module envelope_modulated_phaser #(
    parameter int MAX_STAGES = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_audio_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_audio_out,
    output logic [15:0]        o_envelope_level,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);

    localparam int SW    = (MAX_STAGES > 2) ? $clog2(MAX_STAGES) : 1;
    localparam int NW    = $clog2(MAX_STAGES + 1);
    localparam int N_RST = (MAX_STAGES < 4) ? MAX_STAGES : 4;

    // Configuration
    logic [15:0] r_depth;
    logic [14:0] r_fbg;
    logic [15:0] r_wet;
    logic [NW-1:0] r_n;
    logic [23:0] r_step;
    logic [14:0] r_center;
    logic [7:0]  r_min;

    // Persistent state
    logic [31:0]        r_phase;
    logic [31:0]        r_env;
    logic signed [23:0] r_fb;
    logic signed [23:0] r_in_hist  [MAX_STAGES];
    logic signed [23:0] r_out_hist [MAX_STAGES];

    // Per-item working registers
    eph_pkg::t_state    r_state;
    eph_pkg::t_state    n_state;
    logic signed [23:0] r_x23;
    logic [31:0]        r_abs;
    logic               r_up;
    logic [15:0]        r_sin_base;
    logic               r_sin_neg;
    logic [15:0]        r_lfo15;
    logic [15:0]        r_spread;
    logic signed [23:0] r_sample;
    logic [SW-1:0]      r_s;
    logic [17:0]        r_off;
    logic signed [39:0] r_acc;
    logic               r_out_valid;
    logic signed [15:0] r_audio_out;
    logic [15:0]        r_env_out;

    eph_pkg::t_mul_req  w_req;
    logic signed [59:0] w_prod;
    eph_pkg::t_sin_pts  w_pts;
    logic signed [25:0] w_sin_sum;
    logic [15:0]        w_sin_v;
    logic [16:0]        w_lfo_sum;
    logic [16:0]        w_half;
    logic signed [18:0] w_t;
    logic signed [18:0] w_f;
    logic [14:0]        w_fclamp;
    logic signed [24:0] w_cbase;
    logic signed [25:0] w_cdelta;
    logic [15:0]        w_cfrac;
    logic signed [25:0] w_c;
    logic signed [24:0] w_diff;
    logic signed [23:0] w_y;
    logic signed [16:0] w_res;
    logic [4:0]         w_cnt_raw;
    logic [4:0]         w_cnt;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_last;

    eph_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    eph_coef u_coef (
        .i_clk   (i_clk),
        .i_load  (r_state == eph_pkg::ST_COEF),
        .i_freq  (w_fclamp),
        .o_base  (w_cbase),
        .o_delta (w_cdelta),
        .o_frac  (w_cfrac)
    );

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = (r_s == SW'(r_n - NW'(1)));

    // Stage count written is clamped into the range the chain supports
    assign w_cnt_raw = {1'b0, i_cfg_data[3:0]};
    assign w_cnt = (w_cnt_raw < 5'd2) ? 5'd2 :
                   ((w_cnt_raw > 5'(MAX_STAGES)) ? 5'(MAX_STAGES) : w_cnt_raw);

    // LFO sine: base point plus interpolated slope, folded by quadrant
    assign w_pts     = eph_pkg::sin_pts(r_phase);
    assign w_sin_sum = $signed({2'b0, r_sin_base, 8'd0}) + 26'(w_prod);
    assign w_sin_v   = w_sin_sum[23:8];
    assign w_lfo_sum = r_sin_neg ? (17'd32768 - {1'b0, w_sin_v})
                                 : (17'd32768 + {1'b0, w_sin_v});

    // Depth scale: 0.5 + 0.5 * envelope
    assign w_half = 17'd32768 + {1'b0, r_env[31:16]};

    // Stage sweep position: LFO centred on zero plus the stage offset
    assign w_t = $signed({3'b0, r_lfo15}) - 19'sd16384 + $signed({2'b0, r_off[17:1]});

    // Swept frequency, clamped to [min, 0.45]
    assign w_f = $signed({4'b0, r_center}) + 19'(w_prod >>> 15);
    always_comb begin
        if (w_f < $signed({11'b0, r_min})) begin
            w_fclamp = {7'b0, r_min};
        end else if (w_f > 19'sd29491) begin
            w_fclamp = 15'd29491;
        end else begin
            w_fclamp = w_f[14:0];
        end
    end

    assign w_c    = 26'(w_cbase) + 26'(w_prod >>> 16);
    assign w_diff = 25'(r_sample) - 25'(r_out_hist[r_s]);
    assign w_y    = eph_pkg::sat24(32'(w_prod >>> 23) + 32'(r_in_hist[r_s]));
    assign w_res  = 17'(r_acc >>> 23);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eph_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier operands; a product is used one state later
    always_comb begin
        n_state = r_state;
        w_req.a = '0;
        w_req.b = '0;
        case (r_state)
            eph_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = eph_pkg::ST_SIN;
                end
            end
            eph_pkg::ST_SIN: begin
                w_req.a = 33'($signed({1'b0, w_pts.b}) - $signed({1'b0, w_pts.a}));
                w_req.b = 27'({1'b0, r_phase[24:17]});
                n_state = eph_pkg::ST_SIN2;
            end
            eph_pkg::ST_SIN2: begin
                w_req.a = r_up ? 33'(r_abs - r_env) : 33'(r_env - r_abs);
                w_req.b = r_up ? 27'(eph_pkg::ATTACK_Q32) : 27'(eph_pkg::RELEASE_Q32);
                n_state = eph_pkg::ST_ENV;
            end
            eph_pkg::ST_ENV: begin
                w_req.a = 33'(r_fb);
                w_req.b = 27'(r_fbg);
                n_state = eph_pkg::ST_EFF;
            end
            eph_pkg::ST_EFF: begin
                w_req.a = 33'(r_depth);
                w_req.b = 27'(w_half[16:1]);
                n_state = eph_pkg::ST_SPR;
            end
            eph_pkg::ST_SPR: begin
                w_req.a = 33'(r_center);
                w_req.b = 27'(w_prod[30:15]);
                n_state = eph_pkg::ST_SPRW;
            end
            eph_pkg::ST_SPRW: begin
                n_state = eph_pkg::ST_FREQ;
            end
            eph_pkg::ST_FREQ: begin
                w_req.a = 33'(w_t);
                w_req.b = 27'(r_spread);
                n_state = eph_pkg::ST_COEF;
            end
            eph_pkg::ST_COEF: begin
                n_state = eph_pkg::ST_INTP;
            end
            eph_pkg::ST_INTP: begin
                w_req.a = 33'(w_cdelta);
                w_req.b = 27'(w_cfrac);
                n_state = eph_pkg::ST_YMUL;
            end
            eph_pkg::ST_YMUL: begin
                w_req.a = 33'(w_diff);
                w_req.b = 27'(w_c);
                n_state = eph_pkg::ST_UPD;
            end
            eph_pkg::ST_UPD: begin
                n_state = w_last ? eph_pkg::ST_MIX1 : eph_pkg::ST_FREQ;
            end
            eph_pkg::ST_MIX1: begin
                w_req.a = 33'(r_x23);
                w_req.b = 27'(17'd32768 - {1'b0, r_wet});
                n_state = eph_pkg::ST_MIX2;
            end
            eph_pkg::ST_MIX2: begin
                w_req.a = 33'(r_sample);
                w_req.b = 27'(r_wet);
                n_state = eph_pkg::ST_MIX3;
            end
            eph_pkg::ST_MIX3: begin
                n_state = eph_pkg::ST_FIN;
            end
            eph_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = eph_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = eph_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration, persistent state and stage histories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= 16'd16384;
            r_fbg    <= 15'd16384;
            r_wet    <= 16'd16384;
            r_n      <= NW'(N_RST);
            r_step   <= 24'd447392;
            r_center <= 15'd1365;
            r_min    <= 8'd27;
            r_phase  <= '0;
            r_env    <= '0;
            r_fb     <= '0;
            for (int s = 0; s < MAX_STAGES; s++) begin
                r_in_hist[s]  <= '0;
                r_out_hist[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    eph_pkg::CFG_DEPTH: begin
                        r_depth <= (i_cfg_data[15:0] > eph_pkg::ONE_Q15) ?
                                   eph_pkg::ONE_Q15 : i_cfg_data[15:0];
                    end
                    eph_pkg::CFG_FEEDBACK: begin
                        r_fbg <= (i_cfg_data[14:0] > eph_pkg::FB_MAX) ?
                                 eph_pkg::FB_MAX : i_cfg_data[14:0];
                    end
                    eph_pkg::CFG_WET: begin
                        r_wet <= (i_cfg_data[15:0] > eph_pkg::ONE_Q15) ?
                                 eph_pkg::ONE_Q15 : i_cfg_data[15:0];
                    end
                    eph_pkg::CFG_STAGES: begin
                        r_n <= NW'(w_cnt);
                        // drop the history of stages no longer in use
                        for (int s = 0; s < MAX_STAGES; s++) begin
                            if (5'(s) >= w_cnt) begin
                                r_in_hist[s]  <= '0;
                                r_out_hist[s] <= '0;
                            end
                        end
                    end
                    eph_pkg::CFG_LFO_STEP: r_step   <= i_cfg_data;
                    eph_pkg::CFG_CENTER:   r_center <= i_cfg_data[14:0];
                    eph_pkg::CFG_MIN_FREQ: r_min    <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                eph_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_phase <= r_phase + 32'(r_step);
                    end
                end
                eph_pkg::ST_ENV: begin
                    // attack rises toward the level, release decays, step truncated
                    if (r_up) begin
                        r_env <= r_env + 32'(w_prod[59:32]);
                    end else begin
                        r_env <= r_env - 32'(w_prod[59:32]);
                    end
                end
                eph_pkg::ST_UPD: begin
                    r_in_hist[r_s]  <= r_sample;
                    r_out_hist[r_s] <= w_y;
                end
                eph_pkg::ST_MIX1: begin
                    r_fb <= r_sample;
                end
                default: begin
                end
            endcase
        end
    end

    // Per-item datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            eph_pkg::ST_IDLE: begin
                r_x23 <= {i_audio_in, 8'd0};
                // the most negative sample folds to 0x8000, as wanted
                r_abs <= {i_audio_in[15] ? 16'(-i_audio_in) : i_audio_in, 16'd0};
            end
            eph_pkg::ST_SIN: begin
                r_sin_base <= w_pts.a;
                r_sin_neg  <= r_phase[31];
                r_up       <= r_abs > r_env;
            end
            eph_pkg::ST_SIN2: begin
                r_lfo15 <= w_lfo_sum[16:1];
            end
            eph_pkg::ST_EFF: begin
                r_sample <= eph_pkg::sat24(32'(r_x23) + 32'(w_prod >>> 15));
            end
            eph_pkg::ST_SPRW: begin
                r_spread <= w_prod[30:15];
                r_s      <= '0;
                r_off    <= '0;
            end
            eph_pkg::ST_UPD: begin
                r_sample <= w_y;
                r_s      <= r_s + SW'(1);
                r_off    <= r_off + 18'(eph_pkg::STAGE_RECIP[r_n]);
            end
            eph_pkg::ST_MIX2: begin
                r_acc <= 40'(w_prod);
            end
            eph_pkg::ST_MIX3: begin
                r_acc <= r_acc + 40'(w_prod);
            end
            default: begin
            end
        endcase
    end

    // Output register: load on finish, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == eph_pkg::ST_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == eph_pkg::ST_FIN && w_out_free) begin
            if (w_res > 17'sd32767) begin
                r_audio_out <= 16'sh7FFF;
            end else if (w_res < -17'sd32768) begin
                r_audio_out <= 16'sh8000;
            end else begin
                r_audio_out <= w_res[15:0];
            end
            r_env_out <= r_env[31:16];
        end
    end

    assign o_in_stall       = (r_state != eph_pkg::ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_audio_out      = r_audio_out;
    assign o_envelope_level = r_env_out;

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == eph_pkg::ST_SIN))
        else $error("accepted item did not start the sequence");

    a_stage_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eph_pkg::ST_UPD) |-> ({1'b0, r_s} < {1'b0, r_n}))
        else $error("stage index beyond stages in use");

    a_lfo_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eph_pkg::ST_SIN2) |=> (r_lfo15 <= 16'd32768))
        else $error("LFO value out of range");

    a_env_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_envelope_level <= 16'd32768))
        else $error("envelope level out of range");

endmodule

@@ verif/envelope_modulated_phaser_checker.sv @@
// ---------------------------------------------------------------------------
// envelope_modulated_phaser_checker
// Watches the sample, result and register ports, predicts each mixed output
// sample and envelope level, and counts every mismatch.
// ---------------------------------------------------------------------------
module envelope_modulated_phaser_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_audio_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_audio_out,
    input  logic [15:0]        i_envelope_level,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTAGE = 12;

    typedef struct {
        logic signed [15:0] mix;
        logic [15:0]        level;
    } t_phaser_out;

    t_phaser_out expected_out_q[$];

    longint coef_tab [0:eph_pkg::COEF_DEPTH];

    logic [15:0] depth_r, wet_r;
    logic [14:0] fb_gain_r, center_r;
    logic [3:0]  stages_r;
    logic [23:0] lfo_step_r;
    logic [7:0]  min_freq_r;

    logic [31:0] lfo_phase;
    logic [31:0] env_acc;
    longint      fb_sample;
    longint      hist_in  [0:NSTAGE-1];
    longint      hist_out [0:NSTAGE-1];

    function automatic longint sine_of(input logic [31:0] ph);
        int     k;
        longint lo;
        longint hi;
        longint v;
        k = int'(ph[29:25]);
        if (ph[30]) begin
            lo = longint'(eph_pkg::QSINE[32 - k]);
            hi = longint'(eph_pkg::QSINE[31 - k]);
        end else begin
            lo = longint'(eph_pkg::QSINE[k]);
            hi = longint'(eph_pkg::QSINE[k + 1]);
        end
        v = (lo * (256 - longint'(ph[24:17])) + hi * longint'(ph[24:17])) >>> 8;
        return ph[31] ? -v : v;
    endfunction

    function automatic longint clip24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic int active_stages(input logic [3:0] n);
        if (n < 2) return 2;
        if (n > NSTAGE) return NSTAGE;
        return int'(n);
    endfunction

    // Interpolate the all-pass coefficient for a Q0.16 frequency.
    function automatic longint allpass_coef(input longint f);
        logic [31:0] pos;
        int          k;
        longint      a;
        longint      b;
        pos = 32'(f * 2 * eph_pkg::COEF_DEPTH);
        k = int'(pos[31:16]);
        if (k >= eph_pkg::COEF_DEPTH) k = eph_pkg::COEF_DEPTH - 1;
        a = coef_tab[k];
        b = coef_tab[k + 1];
        return a + (((b - a) * longint'(pos[15:0])) >>> 16);
    endfunction

    function automatic void reset_model();
        depth_r = 16'd16384; fb_gain_r = 15'd16384; wet_r = 16'd16384; stages_r = 4'd4;
        lfo_step_r = 24'd447392; center_r = 15'd1365; min_freq_r = 8'd27;
        lfo_phase = '0; env_acc = '0; fb_sample = 0;
        for (int s = 0; s < NSTAGE; s++) begin
            hist_in[s] = 0;
            hist_out[s] = 0;
        end
    endfunction

    function automatic void write_reg(input logic [2:0] idx, input logic [23:0] d);
        case (eph_pkg::t_cfg_idx'(idx))
            eph_pkg::CFG_DEPTH:
                depth_r = d[15:0] > eph_pkg::ONE_Q15 ? eph_pkg::ONE_Q15 : d[15:0];
            eph_pkg::CFG_FEEDBACK:
                fb_gain_r = d[14:0] > eph_pkg::FB_MAX ? eph_pkg::FB_MAX : d[14:0];
            eph_pkg::CFG_WET:
                wet_r = d[15:0] > eph_pkg::ONE_Q15 ? eph_pkg::ONE_Q15 : d[15:0];
            eph_pkg::CFG_STAGES: begin
                stages_r = d[3:0];
                // drop the history of every stage now out of use
                for (int s = active_stages(stages_r); s < NSTAGE; s++) begin
                    hist_in[s] = 0;
                    hist_out[s] = 0;
                end
            end
            eph_pkg::CFG_LFO_STEP: lfo_step_r = d;
            eph_pkg::CFG_CENTER:   center_r   = d[14:0];
            eph_pkg::CFG_MIN_FREQ: min_freq_r = d[7:0];
            default: ;
        endcase
    endfunction

    function automatic t_phaser_out phaser_predict(input logic signed [15:0] x);
        t_phaser_out r;
        longint      x23, smp, t, f, c, y, total;
        logic [31:0] mag;
        longint      lfo15, env15, half, eff, spread;
        int          n;
        x23 = longint'(x) * 256;
        lfo_phase = lfo_phase + 32'(lfo_step_r);
        lfo15 = (32768 + sine_of(lfo_phase)) >>> 1;
        mag = 32'((x < 0 ? -longint'(x) : longint'(x)) << 16);
        if (mag > env_acc)
            env_acc = env_acc + 32'((longint'(mag - env_acc)
                      * longint'(eph_pkg::ATTACK_Q32)) >> 32);
        else
            env_acc = env_acc - 32'((longint'(env_acc - mag)
                      * longint'(eph_pkg::RELEASE_Q32)) >> 32);
        env15  = longint'(env_acc[31:16]);
        half   = (32768 + env15) >> 1;
        eff    = (longint'(depth_r) * half) >> 15;
        spread = (longint'(center_r) * eff) >> 15;
        smp = clip24(x23 + ((fb_sample * longint'(fb_gain_r)) >>> 15));
        n = active_stages(stages_r);
        for (int s = 0; s < n; s++) begin
            t = lfo15 - 16384
                + ((longint'(s) * longint'(eph_pkg::STAGE_RECIP[n])) >> 1);
            f = longint'(center_r) + ((spread * t) >>> 15);
            if (f < longint'(min_freq_r)) f = longint'(min_freq_r);
            if (f > 29491) f = 29491;
            c = allpass_coef(f);
            y = ((c * (smp - hist_out[s])) >>> 23) + hist_in[s];
            hist_in[s]  = smp;
            hist_out[s] = clip24(y);
            smp = hist_out[s];
        end
        fb_sample = smp;
        total = x23 * (32768 - longint'(wet_r)) + smp * longint'(wet_r);
        total = total >>> 23;
        if (total > 32767) total = 32767;
        if (total < -32768) total = -32768;
        r.mix   = 16'(total);
        r.level = env15[15:0];
        return r;
    endfunction

    // Coefficient table of (tan-1)/(tan+1) over a quarter turn.
    initial begin
        logic [31:0] ph;
        longint      s, c, den;
        for (int k = 0; k <= eph_pkg::COEF_DEPTH; k++) begin
            ph  = 32'(k) << 22;
            s   = sine_of(ph);
            c   = sine_of(ph + 32'h4000_0000);
            den = s + c;
            if (den <= 0) den = 1;
            coef_tab[k] = ((s - c) * 8388608) / den;
        end
        o_fail_count = 0;
        reset_model();
    end

    assign o_pending = expected_out_q.size();

    always @(posedge i_clk) begin
        t_phaser_out e;
        if (!i_rst_n) begin
            reset_model();
            expected_out_q.delete();
        end else begin
            if (i_cfg_we) write_reg(i_cfg_idx, i_cfg_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_out_q.size() == 0) begin
                    $display("%0t: result with none expected: audio_out %0d envelope_level %0d",
                             $realtime, i_audio_out, i_envelope_level);
                    o_fail_count++;
                end else begin
                    e = expected_out_q.pop_front();
                    if (i_audio_out !== e.mix) begin
                        $display("%0t: audio_out expected %0d actual %0d",
                                 $realtime, e.mix, i_audio_out);
                        o_fail_count++;
                    end
                    if (i_envelope_level !== e.level) begin
                        $display("%0t: envelope_level expected %0d actual %0d",
                                 $realtime, e.level, i_envelope_level);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_out_q.push_back(phaser_predict(i_audio_in));
        end
    end

endmodule

@@ verif/envelope_modulated_phaser_test.sv @@
// ---------------------------------------------------------------------------
// envelope_modulated_phaser_test
// Drives samples and register settings into the phaser under random idling
// and back-pressure; the checker beside it predicts and compares each result.
// ---------------------------------------------------------------------------
module envelope_modulated_phaser_test;
    timeunit 1ns;
    timeprecision 1ps;

    // index beyond the register list, which the block must ignore
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    // worst-case latency at twelve stages plus margin
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 245;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] audio_in;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] audio_out;
    logic [15:0]        envelope_level;
    logic               cfg_we;
    logic [2:0]         cfg_idx;
    logic [23:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;

    envelope_modulated_phaser u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_audio_in       (audio_in),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_audio_out      (audio_out),
        .o_envelope_level (envelope_level),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    envelope_modulated_phaser_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_audio_in       (audio_in),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_audio_out      (audio_out),
        .i_envelope_level (envelope_level),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: random stall, or a long hold-off on request so the block
    // backs up and stalls its input while samples keep being offered.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offer one sample, idle first at random, and hold it until accepted.
    task automatic offer_sample(input logic signed [15:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        audio_in <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Write one register; the extra cycle keeps enable pulses apart.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Lower valid and wait until every predicted result has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return 16'($urandom);
        if (pick < 7) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return 16'($signed($urandom_range(0, 255)) - 128);
    endfunction

    // Register settings per phase: both extremes, then in-range and raw random.
    task automatic set_phase_regs(input int p);
        case (p)
            0: begin
                write_reg(eph_pkg::CFG_DEPTH,    24'hFFFFFF);
                write_reg(eph_pkg::CFG_FEEDBACK, 24'hFFFFFF);
                write_reg(eph_pkg::CFG_WET,      24'hFFFFFF);
                write_reg(eph_pkg::CFG_STAGES,   24'hFFFFFF);
                write_reg(eph_pkg::CFG_LFO_STEP, 24'hFFFFFF);
                write_reg(eph_pkg::CFG_CENTER,   24'hFFFFFF);
                write_reg(eph_pkg::CFG_MIN_FREQ, 24'hFFFFFF);
            end
            1: begin
                // minimum frequency clamp of zero gives a coefficient of -1
                write_reg(eph_pkg::CFG_DEPTH,    24'd0);
                write_reg(eph_pkg::CFG_FEEDBACK, 24'd0);
                write_reg(eph_pkg::CFG_WET,      24'd0);
                write_reg(eph_pkg::CFG_STAGES,   24'd0);
                write_reg(eph_pkg::CFG_LFO_STEP, 24'd0);
                write_reg(eph_pkg::CFG_CENTER,   24'd0);
                write_reg(eph_pkg::CFG_MIN_FREQ, 24'd0);
            end
            3: begin
                write_reg(eph_pkg::CFG_DEPTH,    24'($urandom));
                write_reg(eph_pkg::CFG_FEEDBACK, 24'($urandom));
                write_reg(eph_pkg::CFG_WET,      24'($urandom));
                write_reg(eph_pkg::CFG_STAGES,   24'($urandom));
                write_reg(eph_pkg::CFG_LFO_STEP, 24'($urandom));
                write_reg(eph_pkg::CFG_CENTER,   24'($urandom));
                write_reg(eph_pkg::CFG_MIN_FREQ, 24'($urandom));
                write_reg(CFG_UNUSED,            24'($urandom));
            end
            default: begin
                write_reg(eph_pkg::CFG_DEPTH,    24'($urandom_range(0, 32768)));
                write_reg(eph_pkg::CFG_FEEDBACK, 24'($urandom_range(0, 31129)));
                write_reg(eph_pkg::CFG_WET,      24'($urandom_range(0, 32768)));
                write_reg(eph_pkg::CFG_STAGES,   24'($urandom_range(2, 12)));
                write_reg(eph_pkg::CFG_LFO_STEP, 24'($urandom_range(223, 10737418)));
                write_reg(eph_pkg::CFG_CENTER,   24'($urandom_range(6, 29491)));
                write_reg(eph_pkg::CFG_MIN_FREQ, 24'($urandom_range(6, 164)));
            end
        endcase
    endtask

    initial begin
        logic signed [15:0] directed [$];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        audio_in      = '0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 47;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sample extremes and alternating bits at reset settings,
        // a loud run to lift the envelope, then silence to let it release.
        directed = '{16'sh0000, 16'sh7FFF, 16'sh8000, -16'sd1, 16'sd1, 16'sh5555,
                     16'shAAAA, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                     16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000,
                     16'sh0001, 16'shFFFF};
        foreach (directed[i]) offer_sample(directed[i]);

        for (int p = 0; p < 5; p++) begin
            drain();
            set_phase_regs(p);
            // idle pattern: sender 31/receiver 47, swapped, then none
            send_idle_pct = (p < 2) ? 31 : (p < 4) ? 47 : 0;
            recv_idle_pct = (p < 2) ? 47 : (p < 4) ? 31 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ((p == 0 || p == 4) && i == 20) hold_req = 1'b1;
                offer_sample(random_sample());
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("** envelope_modulated_phaser: PASSED **");
        end else begin
            $display("** envelope_modulated_phaser: FAILED **");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("** envelope_modulated_phaser: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/eph_pkg.sv
sv/eph_mul.sv
sv/eph_coef.sv
sv/envelope_modulated_phaser.sv
verif/envelope_modulated_phaser_checker.sv
verif/envelope_modulated_phaser_test.sv
